// ----- src/assert_macros.svh -----
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ----- src/cmac_pkg.sv -----
// ----------------------------------------------------------------------------
// cmac_pkg
// Shared types, constants and AES helper functions for the CMAC engine.
// ----------------------------------------------------------------------------
package cmac_pkg;

  localparam int RoundKeyCount = 44;
  localparam logic [7:0] GfPoly = 8'h87;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow  = 1'b1;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  byte_count;
    logic        last_block;
  } cmac_in_t;

  typedef struct packed {
    logic [63:0] tag_high;
    logic [63:0] tag_low;
  } cmac_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_DONE,
    ST_OUT
  } cmac_state_t;

  // controller to datapath
  typedef struct packed {
    logic expand_init;   // load key into expansion registers, start L encrypt
    logic expand_step;   // one round of key expansion and encrypt
    logic subkeys_load;  // derive K1, K2 from L
    logic block_load;    // prepare message block and add round key 0
    logic round_step;    // one AES round
    logic block_done;    // commit chain / result
  } cmac_cmd_t;

  typedef struct packed {
    logic last_round;    // round counter at round 10
  } cmac_sts_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01;  4'd2: v = 8'h02;  4'd3: v = 8'h04;  4'd4: v = 8'h08;
      4'd5: v = 8'h10;  4'd6: v = 8'h20;  4'd7: v = 8'h40;  4'd8: v = 8'h80;
      4'd9: v = 8'h1b;  4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // state byte i is bits [127-8i -: 8]; column c = bytes 4c..4c+3
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic final_round);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++) t[4*c+k] = b[4*((c+k)%4)+k];
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = final_round ? t[i] : m[i];
    return r ^ rk;
  endfunction

  function automatic logic [127:0] next_round_key(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    t[31:24] = t[31:24] ^ rcon(r);
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? GfPoly : 8'h00)};
  endfunction

endpackage

// ----- src/cmac_ram.sv -----
// ----------------------------------------------------------------------------
// cmac_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cmac_ram #(
  parameter int Width = 32,
  parameter int Depth = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- src/cmac_ctrl.sv -----
// ----------------------------------------------------------------------------
// cmac_ctrl
// Sequencer: key preparation, block load, ten rounds, result hand-off.
// ----------------------------------------------------------------------------
module cmac_ctrl
  import cmac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  input  logic        key_write,
  input  cmac_sts_t   sts,
  output cmac_cmd_t   cmd
);
  cmac_state_t state, state_next;
  logic keys_ready;
  logic last_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      keys_ready <= 1'b0;
      last_held <= 1'b0;
    end else begin
      state <= state_next;
      if (key_write) keys_ready <= 1'b0;
      else if (state == ST_EXPAND && sts.last_round) keys_ready <= 1'b1;
      if (state == ST_IDLE && in_valid) last_held <= in_last;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = keys_ready ? ST_LOAD : ST_EXPAND;
      ST_EXPAND: if (sts.last_round) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_ROUND;
      ST_ROUND:  if (sts.last_round) state_next = ST_DONE;
      ST_DONE:   state_next = last_held ? ST_OUT : ST_IDLE;
      ST_OUT:    if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // item held on port until ST_LOAD; accepted there
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE:   cmd.expand_init = in_valid && !keys_ready;
      ST_EXPAND: begin
        cmd.expand_step = 1'b1;
        cmd.subkeys_load = sts.last_round;
      end
      ST_LOAD: begin
        cmd.block_load = 1'b1;
        in_stall = 1'b0;
      end
      ST_ROUND:  cmd.round_step = 1'b1;
      ST_DONE:   cmd.block_done = 1'b1;
      ST_OUT:    out_valid = 1'b1;
      default:   ;
    endcase
  end
endmodule

// ----- src/cmac_dp.sv -----
// ----------------------------------------------------------------------------
// cmac_dp
// Datapath: round-key expansion into RAM, shared AES round, CMAC chaining.
// ----------------------------------------------------------------------------
module cmac_dp
  import cmac_pkg::*;
#(
  parameter int RoundKeys = RoundKeyCount
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_data,
  input  cmac_in_t    din,
  output cmac_out_t   dout,
  input  cmac_cmd_t   cmd,
  output cmac_sts_t   sts
);
  localparam int Aw = $clog2(RoundKeys / 4);
  localparam int Rounds = RoundKeys / 4 - 1;

  logic [63:0]  key_high, key_low;
  logic [127:0] rkey;      // running round key during expansion
  logic [127:0] st;
  logic [127:0] chain, k1, k2;
  logic [3:0]   rnd;
  logic [127:0] rk_rd;
  logic [Aw-1:0] rd_addr;
  logic [127:0] rk_new;
  logic [127:0] blk, msk, pad;
  logic [4:0]   cnt;

  assign rk_new = next_round_key(rkey, rnd + 4'd1);

  // round keys stored 128 bits per row; row r = round r
  cmac_ram #(.Width(128), .Depth(RoundKeys / 4)) u_rk (
    .clk(clk), .we(cmd.expand_step), .waddr(Aw'(rnd + 4'd1)), .wdata(rk_new),
    .raddr(rd_addr), .rdata(rk_rd)
  );

  // row 0 lives in rk0; read one row ahead, row 1 during the load cycle
  always_comb begin
    rd_addr = Aw'(rnd + 4'd2);
    if (cmd.block_load || rnd >= 4'(Rounds - 1)) rd_addr = Aw'(1);
  end

  // high on the step that performs the final round
  assign sts.last_round = (rnd == 4'(Rounds - 1));

  always_comb begin
    cnt = (din.byte_count > 5'd16) ? 5'd16 : din.byte_count;
    for (int i = 0; i < 16; i++) begin
      msk[127-8*i -: 8] = (5'(i) < cnt) ? 8'hff : 8'h00;
      pad[127-8*i -: 8] = (5'(i) == cnt) ? PadByte : 8'h00;
    end
    blk = {din.block_high, din.block_low};
    if (din.last_block) begin
      if (cnt == 5'd16) blk = blk ^ k1;
      else blk = ((blk & msk) | pad) ^ k2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0; key_low <= '0;
      chain <= '0; k1 <= '0; k2 <= '0;
      rnd <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CfgKeyHigh) key_high <= cfg_data;
        else key_low <= cfg_data;
      end
      if (cmd.expand_init) begin
        rnd <= '0;
      end else if (cmd.expand_step || cmd.round_step) begin
        rnd <= rnd + 4'd1;
      end else if (cmd.block_load) begin
        rnd <= '0;
      end
      if (cmd.subkeys_load) begin
        k1 <= gf_double(aes_round(st, rk_new, 1'b1));
        k2 <= gf_double(gf_double(aes_round(st, rk_new, 1'b1)));
      end
      if (cmd.block_done) begin
        chain <= din.last_block ? '0 : st;
      end
    end
  end

  // row 0 write at expand_init kept separate from the RAM write port:
  // round 0 key stays in a register
  logic [127:0] rk0;

  always_ff @(posedge clk) begin
    if (cmd.expand_init) begin
      rkey <= {key_high, key_low};
      rk0  <= {key_high, key_low};
      st   <= {key_high, key_low};        // zero block xor round key 0
    end else if (cmd.expand_step) begin
      rkey <= rk_new;
      st   <= aes_round(st, rk_new, rnd == 4'(Rounds - 1));
    end else if (cmd.block_load) begin
      st   <= blk ^ chain ^ rk0;
    end else if (cmd.round_step) begin
      st   <= aes_round(st, (rnd == 4'd0) ? rk_rd : rk_rd, rnd == 4'(Rounds - 1));
    end
    if (cmd.block_done) dout <= {st[127:64], st[63:0]};
  end
endmodule

// ----- src/aes128_cmac_engine.sv -----
// ----------------------------------------------------------------------------
// aes128_cmac_engine
// AES-128 CMAC (RFC 4493) with one AES round per clock.
// ----------------------------------------------------------------------------
// Each message block runs from one input beat to the next through an idle state
// in which the waiting beat is seen, a load state, ten rounds on the shared
// round unit and a commit state; the CBC chain through that round unit keeps
// the next block out until the last is committed. The tag beat on a last block
// waits on out_stall in an output state. After reset or a key write, the first
// block passes an expansion state in which the round keys are expanded into the
// round-key RAM and L = AES(K, 0) is computed in the same rounds. The input beat
// is taken in the load state; until then in_stall is high.
module aes128_cmac_engine
  import cmac_pkg::*;
#(
  parameter int ROUND_KEY_COUNT = RoundKeyCount
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  cmac_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output cmac_out_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_data
);
  cmac_cmd_t cmd;
  cmac_sts_t sts;
  cmac_in_t  held;

  // item kept from acceptance until commit
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) held <= in_data;
  end

  cmac_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_last(in_data.last_block), .out_valid(out_valid), .out_stall(out_stall),
    .key_write(cfg_we), .sts(sts), .cmd(cmd)
  );

  cmac_dp #(.RoundKeys(ROUND_KEY_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .din(cmd.block_load ? in_data : held), .dout(out_data), .cmd(cmd), .sts(sts)
  );
endmodule

// ----- src/cmac_checker.sv -----
// ----------------------------------------------------------------------------
// cmac_checker
// Port-level checks for the CMAC engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cmac_checker
  import cmac_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input cmac_out_t out_data
);
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `ASSERT_IMPL(a_no_take_while_out, clk, rst, out_valid, in_stall)
  `ASSERT_NEXT(a_gap_after_take, clk, rst, in_valid && !in_stall, in_stall)
endmodule

bind aes128_cmac_engine cmac_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ----- dv/aes128_cmac_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aes128_cmac_engine_tb
// Self-checking bench for the CMAC engine: directed edge blocks, then random
// messages under several keys, with tags predicted by a behavioural AES model.
// ----------------------------------------------------------------------------
module aes128_cmac_engine_tb;
  import cmac_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  cmac_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  cmac_out_t   out_data;
  logic        cfg_we;
  logic        cfg_addr;
  logic [63:0] cfg_data;

  aes128_cmac_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  localparam int CycleLimit = 400000;

  // predictor state
  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] chain_q, k1_q, k2_q;
  logic         subkeys_valid;
  logic [7:0]   sb [256];

  cmac_in_t     block_queue [$];
  cmac_out_t    tag_queue [$];
  int           fails;
  int           cycles;
  int           in_gap, out_gap;
  bit           quiet;
  logic         in_stall_s;

  function automatic logic [7:0] mul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // FIPS-197 encrypt, byte 0 in the top bits
  function automatic logic [127:0] encrypt(input logic [127:0] pt, input logic [63:0] kh,
                                           input logic [63:0] kl);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  s [16];
    logic [7:0]  r [16];
    logic [7:0]  a0, a1, a2, a3, x;
    logic [127:0] res;
    logic [7:0]  rc;
    w[0] = kh[63:32]; w[1] = kh[31:0]; w[2] = kl[63:32]; w[3] = kl[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sb[t[31:24]] ^ rc, sb[t[23:16]], sb[t[15:8]], sb[t[7:0]]};
        rc = mul2(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ w[i/4][31-8*(i%4) -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int i = 0; i < 16; i++) s[i] = sb[s[i]];
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++) r[4*c+k] = s[4*((c+k)%4)+k];
      for (int c = 0; c < 4; c++) begin
        a0 = r[4*c]; a1 = r[4*c+1]; a2 = r[4*c+2]; a3 = r[4*c+3];
        x = a0 ^ a1 ^ a2 ^ a3;
        if (rnd != 10) begin
          r[4*c]   = a0 ^ x ^ mul2(a0 ^ a1);
          r[4*c+1] = a1 ^ x ^ mul2(a1 ^ a2);
          r[4*c+2] = a2 ^ x ^ mul2(a2 ^ a3);
          r[4*c+3] = a3 ^ x ^ mul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = r[i] ^ w[4*rnd + i/4][31-8*(i%4) -: 8];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
  endfunction

  // one accepted beat through the CMAC chain; queues a tag on the last block
  task automatic predict_tag(input cmac_in_t b);
    logic [127:0] m, l;
    int n;
    if (!subkeys_valid) begin
      l = encrypt(128'h0, key_hi_q, key_lo_q);
      k1_q = dbl(l);
      k2_q = dbl(k1_q);
      subkeys_valid = 1'b1;
    end
    m = {b.block_high, b.block_low};
    if (!b.last_block) begin
      chain_q = encrypt(m ^ chain_q, key_hi_q, key_lo_q);
    end else begin
      n = (b.byte_count > 16) ? 16 : b.byte_count;
      if (n == 16) begin
        m = m ^ k1_q;
      end else begin
        for (int i = 0; i < 16; i++) if (i >= n) m[127-8*i -: 8] = 8'h00;
        m[127-8*n -: 8] = PadByte;
        m = m ^ k2_q;
      end
      tag_queue.push_back(encrypt(m ^ chain_q, key_hi_q, key_lo_q));
      chain_q = '0;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver: present the queue head, drop it once the beat is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall_s) begin
      void'(block_queue.pop_front());
      if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 11);
      if (block_queue.size() > 0 && in_gap == 0) begin
        in_data <= block_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (block_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= block_queue[0];
      end
    end
  end

  // acceptance sampled at the rising edge
  always @(posedge clk) begin
    in_stall_s <= in_stall;
    if (!rst && in_valid && !in_stall) predict_tag(in_data);
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cmac_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tag_queue.size() == 0) begin
        $display("%0t: unexpected tag %h", $realtime, out_data);
        fails++;
      end else begin
        want = tag_queue.pop_front();
        if (out_data.tag_high !== want.tag_high) begin
          $display("%0t: tag_high exp %h got %h", $realtime, want.tag_high, out_data.tag_high);
          fails++;
        end
        if (out_data.tag_low !== want.tag_low) begin
          $display("%0t: tag_low exp %h got %h", $realtime, want.tag_low, out_data.tag_low);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_key(input logic idx, input logic [63:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgKeyHigh) key_hi_q = v; else key_lo_q = v;
    subkeys_valid = 1'b0;
  endtask

  task automatic push_block(input logic [63:0] h, input logic [63:0] l, input logic [4:0] n,
                            input logic last);
    cmac_in_t b;
    b.block_high = h; b.block_low = l; b.byte_count = n; b.last_block = last;
    block_queue.push_back(b);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // let the engine drain before touching the key
  task automatic drain();
    while (block_queue.size() > 0 || tag_queue.size() > 0 || in_valid) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_messages(input int blocks);
    int nb, rest;
    rest = blocks;
    while (rest > 0) begin
      nb = $urandom_range(1, 4);
      for (int i = 0; i < nb; i++) begin
        // byte_count ignored on non-last beats: still toggle all its bits
        push_block(rand64(), rand64(), 5'($urandom_range(0, 31)), i == nb - 1);
        if (i == nb - 1 && $urandom_range(0, 2) == 0) begin
          block_queue[$].byte_count = $urandom_range(0, 2) == 0 ? 5'd16
                                    : 5'($urandom_range(0, 31));
        end
      end
      rest -= nb;
    end
  endtask

  initial begin
    logic [63:0] extremes [3];
    fails = 0; cycles = 0; in_gap = 0; out_gap = 0; quiet = 0;
    rst = 1'b1; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_addr = CfgKeyHigh; cfg_data = '0;
    key_hi_q = '0; key_lo_q = '0; chain_q = '0; k1_q = '0; k2_q = '0;
    subkeys_valid = 1'b0;
    for (int i = 0; i < 256; i++) sb[i] = sbox(8'(i));
    repeat (2) @(posedge clk);
    #0.5 rst = 1'b0;

    // reset key, then RFC 4493 example key
    push_block('0, '0, 5'd0, 1'b1);
    push_block('1, '1, 5'd16, 1'b1);
    drain();
    write_key(CfgKeyHigh, 64'h2b7e151628aed2a6);
    write_key(CfgKeyLow, 64'habf7158809cf4f3c);
    push_block('0, '0, 5'd0, 1'b1);                                // empty message
    push_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
    push_block('1, '1, 5'd3, 1'b0);                                // short, not last
    push_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd15, 1'b1);
    push_block('1, '1, 5'd31, 1'b1);                               // count above 16
    push_block('1, '0, 5'd17, 1'b1);
    for (int n = 1; n < 16; n += 4) push_block('1, '1, 5'(n), 1'b1);
    push_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd8, 1'b0);
    // key change mid-message keeps the chain
    drain();
    write_key(CfgKeyLow, '1);
    push_block(64'h8000000000000000, 64'h1, 5'd16, 1'b1);
    drain();

    extremes = '{64'h0, 64'hffffffffffffffff, 64'h0};
    for (int p = 0; p < 6; p++) begin
      write_key(CfgKeyHigh, p < 3 ? extremes[p] : rand64());
      write_key(CfgKeyLow, p < 3 ? ~extremes[p] : rand64());
      if (p == 5) quiet = 1;
      random_messages(155);
      drain();
    end

    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
